// ===== hdl/sha1ckm_pkg.sv =====
// Package for the SHA-1 candidate key matcher: types, constants and helper functions.
// It has no dependencies.
package sha1ckm_pkg;

  localparam int unsigned Rounds = 80;
  localparam int unsigned MsgBits = 96;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] CharC = 8'h43;
  localparam logic [7:0] CharP = 8'h50;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharA = 8'h41;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } state_t;

  typedef logic [15:0][31:0] window_t;

  // Two decimal digits of a value below 100, as two characters.
  // Tens digit by reciprocal multiply: (v * 205) >> 11 is exact here.
  function automatic logic [15:0] dec2(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    rem  = v - 7'(tens) * 7'd10;
    return {CharZero + 8'(tens), CharZero + 8'(rem)};
  endfunction

  function automatic logic [7:0] hex1(input logic [3:0] n);
    return (n < 4'd10) ? CharZero + 8'(n) : CharA + 8'(n) - 8'd10;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] i);
    if (i < 7'd20) return 32'h5A827999;
    else if (i < 7'd40) return 32'h6ED9EBA1;
    else if (i < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (i < 7'd20) return (b & c) | (~b & d);
    else if (i < 7'd40 || i >= 7'd60) return b ^ c ^ d;
    else return (b & c) | (b & d) | (c & d);
  endfunction

endpackage

// ===== hdl/sha1ckm_round.sv =====
// One registered SHA-1 round with its message schedule window.
// Depends on sha1ckm_pkg.
module sha1ckm_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [6:0]           idx_i,
  input  logic                 valid_i,
  input  sha1ckm_pkg::state_t  st_i,
  input  sha1ckm_pkg::window_t w_i,
  input  logic [23:0]          tag_i,
  output logic                 valid_o,
  output sha1ckm_pkg::state_t  st_o,
  output sha1ckm_pkg::window_t w_o,
  output logic [23:0]          tag_o
);

  logic                 valid_q;
  sha1ckm_pkg::state_t  st_d, st_q;
  sha1ckm_pkg::window_t w_d, w_q;
  logic [23:0]          tag_q;
  logic [31:0]          w_new, t;

  // w_i[0] is the word used by this round; the window shifts by one.
  assign w_new = {w_i[13] ^ w_i[8] ^ w_i[2] ^ w_i[0]} << 1 |
                 {w_i[13] ^ w_i[8] ^ w_i[2] ^ w_i[0]} >> 31;
  assign t = {st_i.a[26:0], st_i.a[31:27]} +
             sha1ckm_pkg::round_f(idx_i, st_i.b, st_i.c, st_i.d) +
             st_i.e + sha1ckm_pkg::round_k(idx_i) + w_i[0];

  always_comb begin
    st_d.a = t;
    st_d.b = st_i.a;
    st_d.c = {st_i.b[1:0], st_i.b[31:2]};
    st_d.d = st_i.c;
    st_d.e = st_i.d;
    w_d = {w_new, w_i[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      w_q   <= w_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign st_o    = st_q;
  assign w_o     = w_q;
  assign tag_o   = tag_q;

endmodule

// ===== hdl/sha1_candidate_key_match_top.sv =====
// Top level of the SHA-1 candidate key matcher: message build, 80 round stages, compare.
// Depends on sha1ckm_pkg and sha1ckm_round.
// One candidate item is taken per cycle while in_stall is low. The pipeline has
// one message build stage, one register per SHA-1 round (80) and one final
// add and compare stage. The whole pipeline advances together and holds in
// place while the output is stalled and a result waits. target_q is captured
// with each item at entry.
module sha1_candidate_key_match_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  year_two_digit_i,
  input  logic [6:0]  week_number_i,
  input  logic [7:0]  code_byte_0_i,
  input  logic [7:0]  code_byte_1_i,
  input  logic [7:0]  code_byte_2_i,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_match_o,
  output logic [39:0] key_value_o
);

  localparam int unsigned N = sha1ckm_pkg::Rounds;

  logic [23:0] target_q;
  logic        en;

  logic                 msg_valid_q;
  sha1ckm_pkg::window_t msg_q;
  logic [23:0]          msg_tag_q;

  logic                 v   [N+1];
  sha1ckm_pkg::state_t  st  [N+1];
  sha1ckm_pkg::window_t win [N+1];
  logic [23:0]          tag [N+1];

  logic        out_valid_q;
  logic        match_q;
  logic [39:0] key_q;
  logic [31:0] h0, h1, h4;

  // Advance when the output slot is empty or being taken.
  assign en       = !out_valid_q || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we) begin
      target_q <= cfg_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_valid_q <= 1'b0;
    end else if (en) begin
      msg_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      msg_q[0]  <= {sha1ckm_pkg::CharC, sha1ckm_pkg::CharP,
                    sha1ckm_pkg::dec2(year_two_digit_i)};
      msg_q[1]  <= {sha1ckm_pkg::dec2(week_number_i),
                    sha1ckm_pkg::hex1(code_byte_0_i[7:4]),
                    sha1ckm_pkg::hex1(code_byte_0_i[3:0])};
      msg_q[2]  <= {sha1ckm_pkg::hex1(code_byte_1_i[7:4]),
                    sha1ckm_pkg::hex1(code_byte_1_i[3:0]),
                    sha1ckm_pkg::hex1(code_byte_2_i[7:4]),
                    sha1ckm_pkg::hex1(code_byte_2_i[3:0])};
      msg_q[3]  <= 32'h8000_0000;
      for (int i = 4; i < 15; i++) msg_q[i] <= '0;
      msg_q[15] <= 32'(sha1ckm_pkg::MsgBits);
      msg_tag_q <= target_q;
    end
  end

  assign v[0]   = msg_valid_q;
  assign st[0]  = '{a: sha1ckm_pkg::H0, b: sha1ckm_pkg::H1, c: sha1ckm_pkg::H2,
                    d: sha1ckm_pkg::H3, e: sha1ckm_pkg::H4};
  assign win[0] = msg_q;
  assign tag[0] = msg_tag_q;

  for (genvar r = 0; r < N; r++) begin : g_round
    sha1ckm_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (7'(r)),
      .valid_i (v[r]),
      .st_i    (st[r]),
      .w_i     (win[r]),
      .tag_i   (tag[r]),
      .valid_o (v[r+1]),
      .st_o    (st[r+1]),
      .w_o     (win[r+1]),
      .tag_o   (tag[r+1])
    );
  end

  assign h0 = sha1ckm_pkg::H0 + st[N].a;
  assign h1 = sha1ckm_pkg::H1 + st[N].b;
  assign h4 = sha1ckm_pkg::H4 + st[N].e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      match_q <= (h4[23:0] == tag[N]);
      key_q   <= {h0, h1[31:24]};
    end
  end

  assign out_valid   = out_valid_q;
  assign is_match_o  = match_q;
  assign key_value_o = key_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(key_value_o) && $stable(is_match_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall |=> out_valid == $past(v[N]))
    else $error("pipeline valid lost");

endmodule
